@@ design/mcst_pkg.sv @@
`timescale 1ns / 1ps
package mcst_pkg;
    typedef enum logic [3:0] {
        OP_TICK = 4'd0, OP_SERVICE = 4'd1, OP_CREATE = 4'd2, OP_DELETE = 4'd3,
        OP_PAUSE = 4'd4, OP_RESUME = 4'd5, OP_SET_REPEAT = 4'd6, OP_SET_PERIOD = 4'd7,
        OP_READY = 4'd8, OP_RESET = 4'd9, OP_READ_TIME = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE = 3'd0, ST_FIRED = 3'd1, ST_DISABLED = 3'd2,
        ST_NO_FREE = 3'd3, ST_NOT_ALLOC = 3'd4
    } t_status;

    localparam logic [31:0] NO_TIMER_READY = 32'hFFFF_FFFF;
    localparam logic [31:0] REPEAT_FOREVER = 32'hFFFF_FFFF;

    // Per-channel evaluation handed from the compare unit to the sequencer.
    typedef struct packed {
        logic        due;
        logic [31:0] remain;
    } t_eval;
endpackage

@@ design/multi_channel_soft_timer.sv @@
`timescale 1ns / 1ps
// Multi-channel soft timer bank.
// Commands enter on start with i_operation, i_channel, i_amount and
// i_repeat_value; an item is taken when start is high and busy is low.
// Every command gives one or more result beats, each shown for exactly one
// cycle with o_valid high; o_last marks the final beat of a command.
// Simple commands (tick, create, delete, pause, resume, set, ready, reset,
// read time) read the channel's table entries from the registered-read
// memories, then update, then present the beat.
// Create searches the allocation bits with a combinational priority encoder.
// A service pass visits the channels one per cycle through a single
// elapsed-versus-period compare unit, issuing each memory read one channel
// ahead of the visit. Fired channels produce a beat in the cycle after
// they are visited; the least remaining time is accumulated in the same
// pass and reported on the closing beat.
// i_cfg_we writes service_enable at any edge; write it only while idle.
// Reset clears the time, the allocation and pause bits and service_enable;
// the period, last-run and repeat memories are not cleared and need no sweep.
// The receiver cannot stall, so beats are never held back.
module multi_channel_soft_timer #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic [3:0]  i_operation,
    input  logic [3:0]  i_channel,
    input  logic [31:0] i_amount,
    input  logic signed [31:0] i_repeat_value,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [3:0]  o_channel_out,
    output logic [31:0] o_result_value,
    output logic        o_last
);
    import mcst_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CW = $clog2(NUM_CHANNELS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_SCAN, S_FINISH
    } t_state;

    t_state r_state;
    logic        r_enable;
    logic [31:0] r_now;
    logic [NUM_CHANNELS-1:0] r_alloc, r_paused;
    logic [3:0]  r_op, r_ch;
    logic [31:0] r_amount, r_rep;
    logic [CW-1:0] r_idx;       // channel whose memory read is issued
    logic [AW-1:0] r_vis;       // channel being visited in the scan
    logic        r_vis_ok;
    logic [31:0] r_best;
    logic        r_valid, r_last;
    logic [2:0]  r_status;
    logic [3:0]  r_chout;
    logic [31:0] r_value;

    // Memories: period, last run time, repeats left.
    logic          per_we, lrt_we, rep_we;
    logic [AW-1:0] per_wa, lrt_wa, rep_wa, rd_addr;
    logic [31:0]   per_wd, lrt_wd, rep_wd;
    logic [31:0]   per_rd, lrt_rd, rep_rd;

    mcst_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_per (
        .i_clk(i_clk), .i_we(per_we), .i_waddr(per_wa), .i_wdata(per_wd),
        .i_raddr(rd_addr), .o_rdata(per_rd));
    mcst_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_lrt (
        .i_clk(i_clk), .i_we(lrt_we), .i_waddr(lrt_wa), .i_wdata(lrt_wd),
        .i_raddr(rd_addr), .o_rdata(lrt_rd));
    mcst_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_rep (
        .i_clk(i_clk), .i_we(rep_we), .i_waddr(rep_wa), .i_wdata(rep_wd),
        .i_raddr(rd_addr), .o_rdata(rep_rd));

    t_eval ev;
    mcst_eval u_eval (.i_now(r_now), .i_last_run(lrt_rd), .i_period(per_rd),
        .o_eval(ev));

    // Lowest free slot.
    logic          free_found;
    logic [AW-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    logic ch_ok;
    assign ch_ok = ({28'd0, r_ch} < 32'(NUM_CHANNELS)) && r_alloc[r_ch[AW-1:0]];
    assign rd_addr = (r_state == S_IDLE) ? i_channel[AW-1:0] : r_idx[AW-1:0];

    // Scan step for the visited channel.
    logic        v_act, v_due, v_fire, v_free;
    logic [31:0] v_rep_new;
    always_comb begin
        v_act     = r_vis_ok && r_alloc[r_vis] && !r_paused[r_vis];
        v_due     = v_act && ev.due;
        v_rep_new = (v_due && rep_rd != 32'd0 && !rep_rd[31]) ? rep_rd - 32'd1 : rep_rd;
        v_fire    = v_due && (rep_rd != 32'd0);
        v_free    = v_act && (v_rep_new == 32'd0);
    end

    // Remaining time after a due channel restarts is its full period.
    logic [31:0] v_remain;
    assign v_remain = v_due ? per_rd : ev.remain;

    always_comb begin
        per_we = 1'b0; lrt_we = 1'b0; rep_we = 1'b0;
        per_wa = r_ch[AW-1:0]; lrt_wa = r_ch[AW-1:0]; rep_wa = r_ch[AW-1:0];
        per_wd = r_amount; lrt_wd = r_now; rep_wd = r_rep;
        if (r_state == S_EXEC) begin
            if (r_op == OP_CREATE) begin
                per_wa = free_idx; lrt_wa = free_idx; rep_wa = free_idx;
                rep_wd = REPEAT_FOREVER;
                per_we = free_found; lrt_we = free_found; rep_we = free_found;
            end else if (ch_ok) begin
                unique case (r_op)
                    OP_SET_REPEAT: rep_we = 1'b1;
                    OP_SET_PERIOD: per_we = 1'b1;
                    OP_READY: begin
                        lrt_we = 1'b1;
                        lrt_wd = r_now - per_rd - 32'd1;
                    end
                    OP_RESET: lrt_we = 1'b1;
                    default: ;
                endcase
            end
        end else if (r_state == S_SCAN) begin
            lrt_wa = r_vis; rep_wa = r_vis;
            lrt_we = v_due; rep_we = v_due;
            rep_wd = v_rep_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_enable <= 1'b0;
            r_now    <= '0;
            r_alloc  <= '0;
            r_paused <= '0;
            r_valid  <= 1'b0;
            r_vis_ok <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_operation;
                        r_ch     <= i_channel;
                        r_amount <= i_amount;
                        r_rep    <= i_repeat_value;
                        // A service pass starts its reads at channel zero.
                        r_idx    <= (i_operation == OP_SERVICE) ? '0
                                                                : CW'(i_channel[AW-1:0]);
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    // Memory data for r_ch is now available.
                    if (r_op == OP_SERVICE && r_enable) begin
                        r_idx    <= CW'(1);
                        r_vis    <= '0;
                        r_vis_ok <= 1'b1;
                        r_best   <= NO_TIMER_READY;
                        r_state  <= S_SCAN;
                    end else begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_valid  <= 1'b1;
                    r_last   <= 1'b1;
                    r_status <= ST_DONE;
                    r_chout  <= 4'd0;
                    r_value  <= 32'd0;
                    r_state  <= S_IDLE;
                    case (r_op) inside
                        OP_TICK:      r_now <= r_now + r_amount;
                        OP_SERVICE: begin
                            r_status <= ST_DISABLED;
                            r_value  <= NO_TIMER_READY;
                        end
                        OP_CREATE: begin
                            if (free_found) begin
                                r_alloc[free_idx]  <= 1'b1;
                                r_paused[free_idx] <= 1'b0;
                                r_chout            <= 4'(free_idx);
                            end else begin
                                r_status <= ST_NO_FREE;
                            end
                        end
                        OP_READ_TIME: r_value <= r_now;
                        OP_DELETE, OP_PAUSE, OP_RESUME, OP_SET_REPEAT,
                        OP_SET_PERIOD, OP_READY, OP_RESET: begin
                            r_chout <= r_ch;
                            if (!ch_ok) begin
                                r_status <= ST_NOT_ALLOC;
                            end else if (r_op == OP_DELETE) begin
                                r_alloc[r_ch[AW-1:0]] <= 1'b0;
                            end else if (r_op == OP_PAUSE) begin
                                r_paused[r_ch[AW-1:0]] <= 1'b1;
                            end else if (r_op == OP_RESUME) begin
                                r_paused[r_ch[AW-1:0]] <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    if (v_free) begin
                        r_alloc[r_vis] <= 1'b0;
                    end
                    if (v_act && !v_free && v_remain < r_best) begin
                        r_best <= v_remain;
                    end
                    if (v_fire) begin
                        r_valid  <= 1'b1;
                        r_last   <= 1'b0;
                        r_status <= ST_FIRED;
                        r_chout  <= 4'(r_vis);
                        r_value  <= 32'd0;
                    end
                    if (r_idx == CW'(NUM_CHANNELS)) begin
                        r_vis_ok <= 1'b0;
                        r_state  <= S_FINISH;
                    end else begin
                        r_vis <= r_idx[AW-1:0];
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_FINISH: begin
                    r_valid  <= 1'b1;
                    r_last   <= 1'b1;
                    r_status <= ST_DONE;
                    r_chout  <= 4'd0;
                    r_value  <= r_best;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_channel_out  = r_chout;
    assign o_result_value = r_value;
    assign o_last         = r_last;
endmodule

@@ design/mcst_ram.sv @@
`timescale 1ns / 1ps
module mcst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/mcst_eval.sv @@
`timescale 1ns / 1ps
// Shared compare unit: elapsed time against period for one channel.
module mcst_eval (
    input  logic [31:0]  i_now,
    input  logic [31:0]  i_last_run,
    input  logic [31:0]  i_period,
    output mcst_pkg::t_eval o_eval
);
    import mcst_pkg::*;
    logic [31:0] elapsed;

    always_comb begin
        elapsed       = i_now - i_last_run;
        o_eval.due    = (elapsed >= i_period);
        o_eval.remain = o_eval.due ? 32'd0 : (i_period - elapsed);
    end
endmodule

@@ design/mcst_checker.sv @@
`timescale 1ns / 1ps
module mcst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic        o_last
);
    import mcst_pkg::*;

    // An accepted command always makes the block busy next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // The closing beat of a command returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("still busy after final beat");

    // Fired beats are never final; all other beats are.
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_FIRED) != o_last))
        else $error("last flag inconsistent with status");

    // A fired beat happens only inside a busy pass.
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FIRED) |-> busy)
        else $error("fired beat outside a pass");

    // No beat while idle without a preceding command.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> !o_valid)
        else $error("beat without command");
endmodule

bind multi_channel_soft_timer mcst_checker u_mcst_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_status(o_status), .o_last(o_last));

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import mcst_pkg::*;

    localparam int NCH = 16;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  chan;
        logic [31:0] value;
        logic        last;
    } t_beat;

    typedef struct {
        t_op         op;
        logic [3:0]  chan;
        logic [31:0] amount;
        logic [31:0] rep;
        bit          typed;
        logic [2:0]  exp_status;
        logic [3:0]  exp_chan;
        logic [31:0] exp_value;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic [3:0]  i_operation = 4'd0;
    logic [3:0]  i_channel = 4'd0;
    logic [31:0] i_amount = 32'd0;
    logic signed [31:0] i_repeat_value = 32'sd0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_channel_out;
    logic [31:0] o_result_value;
    logic        o_last;

    multi_channel_soft_timer #(.NUM_CHANNELS(NCH)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_operation(i_operation), .i_channel(i_channel), .i_amount(i_amount),
        .i_repeat_value(i_repeat_value), .o_valid(o_valid), .o_status(o_status),
        .o_channel_out(o_channel_out), .o_result_value(o_result_value), .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    // Predicted timer bank state.
    logic        svc_en;
    logic [31:0] now_t;
    logic        alloc_q [NCH];
    logic        pause_q [NCH];
    logic [31:0] period_q [NCH];
    logic [31:0] lastrun_q [NCH];
    logic [31:0] reps_q [NCH];

    t_beat pending_beats[$];
    int    errors = 0;
    int    beats_seen = 0;
    int    fired_seen = 0;
    int    items_sent = 0;
    bit    quiet = 0;

    function automatic logic [31:0] time_left(int c);
        logic [31:0] el;
        el = now_t - lastrun_q[c];
        return (el >= period_q[c]) ? 32'd0 : period_q[c] - el;
    endfunction

    function automatic void push_beat(logic [2:0] s, logic [3:0] c, logic [31:0] v, logic l);
        t_beat b;
        b.status = s; b.chan = c; b.value = v; b.last = l;
        pending_beats.push_back(b);
    endfunction

    function automatic void predict_command(t_op op, logic [3:0] ch, logic [31:0] amt,
                                            logic [31:0] rep);
        logic [31:0] best;
        logic [31:0] old;
        bit          found;
        found = 0;
        best = NO_TIMER_READY;
        case (op) inside
            OP_TICK: begin
                now_t = now_t + amt;
                push_beat(ST_DONE, 4'd0, 32'd0, 1'b1);
            end
            OP_SERVICE: begin
                if (!svc_en) begin
                    push_beat(ST_DISABLED, 4'd0, NO_TIMER_READY, 1'b1);
                end else begin
                    for (int c = 0; c < NCH; c++) begin
                        if (alloc_q[c] && !pause_q[c]) begin
                            if (time_left(c) == 32'd0) begin
                                old = reps_q[c];
                                if (old != 32'd0 && !old[31]) reps_q[c] = old - 32'd1;
                                lastrun_q[c] = now_t;
                                if (old != 32'd0) push_beat(ST_FIRED, c[3:0], 32'd0, 1'b0);
                            end
                            if (reps_q[c] == 32'd0) alloc_q[c] = 1'b0;
                        end
                    end
                    for (int c = 0; c < NCH; c++)
                        if (alloc_q[c] && !pause_q[c] && time_left(c) < best)
                            best = time_left(c);
                    push_beat(ST_DONE, 4'd0, best, 1'b1);
                end
            end
            OP_CREATE: begin
                for (int c = 0; c < NCH; c++) begin
                    if (!found && !alloc_q[c]) begin
                        found = 1;
                        alloc_q[c] = 1'b1; pause_q[c] = 1'b0; period_q[c] = amt;
                        reps_q[c] = REPEAT_FOREVER; lastrun_q[c] = now_t;
                        push_beat(ST_DONE, c[3:0], 32'd0, 1'b1);
                    end
                end
                if (!found) push_beat(ST_NO_FREE, 4'd0, 32'd0, 1'b1);
            end
            OP_READ_TIME: push_beat(ST_DONE, 4'd0, now_t, 1'b1);
            OP_DELETE, OP_PAUSE, OP_RESUME, OP_SET_REPEAT, OP_SET_PERIOD, OP_READY,
            OP_RESET: begin
                if (!alloc_q[ch]) begin
                    push_beat(ST_NOT_ALLOC, ch, 32'd0, 1'b1);
                end else begin
                    case (op)
                        OP_DELETE:     alloc_q[ch] = 1'b0;
                        OP_PAUSE:      pause_q[ch] = 1'b1;
                        OP_RESUME:     pause_q[ch] = 1'b0;
                        OP_SET_REPEAT: reps_q[ch] = rep;
                        OP_SET_PERIOD: period_q[ch] = amt;
                        OP_READY:      lastrun_q[ch] = now_t - period_q[ch] - 32'd1;
                        default:       lastrun_q[ch] = now_t;
                    endcase
                    push_beat(ST_DONE, ch, 32'd0, 1'b1);
                end
            end
            default: push_beat(ST_DONE, 4'd0, 32'd0, 1'b1);
        endcase
    endfunction

    // Results cannot be held off, so every strobe is a beat.
    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (o_status == ST_FIRED) fired_seen++;
            if (pending_beats.size() == 0) begin
                $error("unexpected beat status=%0d chan=%0d value=%h",
                       o_status, o_channel_out, o_result_value);
                errors++;
            end else begin
                e = pending_beats.pop_front();
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status); errors++;
                end
                if (o_channel_out !== e.chan) begin
                    $error("channel_out expected %0d actual %0d", e.chan, o_channel_out);
                    errors++;
                end
                if (o_result_value !== e.value) begin
                    $error("result_value expected %h actual %h", e.value, o_result_value);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_last); errors++;
                end
            end
        end
    end

    // Start stays high between back-to-back commands; it drops only for an idle gap.
    task automatic send_command(t_op op, logic [3:0] ch, logic [31:0] amt, logic [31:0] rep);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op; i_channel <= ch; i_amount <= amt; i_repeat_value <= rep;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(op, ch, amt, rep);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_enable(logic v);
        i_cfg_we <= 1'b1; i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        svc_en = v;
    endtask

    function automatic t_row mk(t_op op, logic [3:0] ch, logic [31:0] amt, logic [31:0] rep,
                                bit typed = 0, logic [2:0] s = 0, logic [3:0] c = 0,
                                logic [31:0] v = 0);
        t_row r;
        r.op = op; r.chan = ch; r.amount = amt; r.rep = rep; r.typed = typed;
        r.exp_status = s; r.exp_chan = c; r.exp_value = v;
        return r;
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    function automatic logic [31:0] pick_repeat();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom;
            3: return 32'h7FFF_FFFF;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    t_row rows[$];

    initial begin
        t_op  op;
        svc_en = 0; now_t = 0;
        for (int c = 0; c < NCH; c++) begin
            alloc_q[c] = 0; pause_q[c] = 0; period_q[c] = 0; lastrun_q[c] = 0; reps_q[c] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; the typed expectations are checked against the predictor first.
        rows.push_back(mk(OP_READ_TIME, 0, 0, 0, 1, ST_DONE, 0, 0));
        rows.push_back(mk(OP_SERVICE, 0, 0, 0, 1, ST_DISABLED, 0, NO_TIMER_READY));
        rows.push_back(mk(OP_DELETE, 15, 0, 0, 1, ST_NOT_ALLOC, 15, 0));
        rows.push_back(mk(OP_TICK, 0, 32'hFFFF_FFFF, 0, 1, ST_DONE, 0, 0));
        rows.push_back(mk(OP_READ_TIME, 0, 0, 0, 1, ST_DONE, 0, 32'hFFFF_FFFF));
        rows.push_back(mk(OP_CREATE, 0, 5, 0, 1, ST_DONE, 0, 0));
        rows.push_back(mk(OP_CREATE, 0, 32'hFFFF_FFFF, 0, 1, ST_DONE, 1, 0));
        rows.push_back(mk(OP_CREATE, 0, 0, 0, 1, ST_DONE, 2, 0));
        rows.push_back(mk(OP_SET_REPEAT, 0, 0, 2));
        rows.push_back(mk(OP_SET_REPEAT, 2, 0, 0));
        rows.push_back(mk(OP_SET_REPEAT, 1, 0, 32'h8000_0000));
        rows.push_back(mk(OP_PAUSE, 1, 0, 0));
        rows.push_back(mk(OP_RESUME, 1, 0, 0));
        rows.push_back(mk(OP_READY, 1, 0, 0));
        rows.push_back(mk(OP_TICK, 0, 6, 0));
        rows.push_back(mk(OP_SET_PERIOD, 2, 32'h7FFF_FFFF, 0));
        rows.push_back(mk(OP_RESET, 2, 0, 0));
        rows.push_back(mk(OP_SERVICE, 0, 0, 0));
        rows.push_back(mk(OP_SERVICE, 0, 0, 0));
        rows.push_back(mk(op.first(), 0, 0, 0));
        rows.push_back(mk(t_op'(4'd15), 9, 32'hAAAA_5555, 32'h5555_AAAA, 1, ST_DONE, 0, 0));
        rows.push_back(mk(t_op'(4'd11), 6, 0, 0, 1, ST_DONE, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].op == OP_SERVICE && !rows[i].typed && !svc_en) begin
                drain_results();
                write_enable(1'b1);
            end
            send_command(rows[i].op, rows[i].chan, rows[i].amount, rows[i].rep);
            // Typed rows give a single beat, which is the newest one predicted.
            if (rows[i].typed &&
                (pending_beats[$].status !== rows[i].exp_status ||
                 pending_beats[$].chan !== rows[i].exp_chan ||
                 pending_beats[$].value !== rows[i].exp_value)) begin
                $error("directed row %0d: predictor disagrees with table", i);
                errors++;
            end
        end
        // Fill every slot to reach the no-free case.
        for (int c = 0; c < NCH + 1; c++) send_command(OP_CREATE, 0, pick_period(), 0);

        for (int n = 0; n < 380; n++) begin
            if (n % 100 == 50) begin
                drain_results();
                write_enable(n % 200 == 50 ? 1'b0 : 1'b1);
            end
            if (n == 340) quiet = 1;
            case ($urandom_range(0, 19)) inside
                0, 1, 2:    op = OP_TICK;
                3, 4, 5, 6: op = OP_SERVICE;
                7, 8, 9:    op = OP_CREATE;
                10:         op = OP_DELETE;
                11:         op = OP_PAUSE;
                12:         op = OP_RESUME;
                13, 14:     op = OP_SET_REPEAT;
                15:         op = OP_SET_PERIOD;
                16:         op = OP_READY;
                17:         op = OP_RESET;
                18:         op = OP_READ_TIME;
                default:    op = t_op'($urandom_range(0, 15));
            endcase
            send_command(op, 4'($urandom_range(0, 15)),
                         op == OP_TICK ? (($urandom_range(0, 7) == 0) ? $urandom
                                                                       : $urandom_range(0, 30))
                                       : pick_period(),
                         pick_repeat());
        end
        drain_results();
        $display("Sent %0d commands; checked %0d result beats, %0d of them channel firings.",
                 items_sent, beats_seen, fired_seen);
        if (errors == 0 && pending_beats.size() == 0)
            $display("multi_channel_soft_timer test passed");
        else
            $display("multi_channel_soft_timer test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("multi_channel_soft_timer test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
design/mcst_pkg.sv
design/mcst_ram.sv
design/mcst_eval.sv
design/multi_channel_soft_timer.sv
design/mcst_checker.sv
tb/tb.sv
